@@ src/rti_pkg.sv @@
package rti_pkg;

  // configuration port
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 3;
  localparam int NUM_REGS  = 8;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_X    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_Y    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_Z    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_T_LOW    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_T_HIGH   = 3'd7;

  // non-zero reset values
  localparam logic [CFG_W-1:0] DIR_Z_RESET  = 32'h0001_0000;
  localparam logic [CFG_W-1:0] T_HIGH_RESET = 32'h7fff_ffff;

  // number formats
  localparam int FRAC_BITS     = 16;
  localparam int NUM_IN_FIELDS = 9;
  localparam int MUL_LIMB      = 32;
  localparam int OUT_TDATA_W   = 8;

  // reject reasons
  localparam logic [2:0] RSN_HIT      = 3'd0;
  localparam logic [2:0] RSN_PARALLEL = 3'd1;
  localparam logic [2:0] RSN_BARY_U   = 3'd2;
  localparam logic [2:0] RSN_BARY_V   = 3'd3;
  localparam logic [2:0] RSN_T_RANGE  = 3'd4;

  typedef struct packed {
    logic       hit;
    logic [2:0] reason;
  } rti_result_t;

endpackage

@@ src/rti_mul.sv @@
// Pipelined signed multiplier: A is cut into MUL_LIMB-bit limbs, one partial
// product per limb, then a registered two-level sum.
module rti_mul
  import rti_pkg::*;
#(
  parameter int A_W = 33,
  parameter int B_W = 33
) (
  input  logic                      clk,
  input  logic                      ce,
  input  logic signed [A_W-1:0]     a,
  input  logic signed [B_W-1:0]     b,
  output logic signed [A_W+B_W-1:0] p
);

  localparam int NLIMB = (A_W + MUL_LIMB - 1) / MUL_LIMB;
  localparam int NPAIR = (NLIMB + 1) / 2;
  localparam int EXT_W = NLIMB * MUL_LIMB;
  localparam int PP_W  = MUL_LIMB + 1 + B_W;
  localparam int ACC_W = EXT_W + B_W + 1;
  localparam int P_W   = A_W + B_W;

  logic signed [EXT_W-1:0]    a_ext;
  logic signed [MUL_LIMB:0]   limb     [NLIMB];
  logic signed [PP_W-1:0]     pp_r     [NLIMB];
  logic signed [ACC_W-1:0]    pair_nxt [NPAIR];
  logic signed [ACC_W-1:0]    pair_r   [NPAIR];
  logic signed [ACC_W-1:0]    acc_nxt;
  logic signed [P_W-1:0]      p_r;

  assign a_ext = EXT_W'(a);

  // low limbs are unsigned, the top limb carries the sign
  always_comb begin
    for (int i = 0; i < NLIMB; i++) begin
      if (i == NLIMB - 1) begin
        limb[i] = {a_ext[i*MUL_LIMB + MUL_LIMB - 1], a_ext[i*MUL_LIMB +: MUL_LIMB]};
      end else begin
        limb[i] = {1'b0, a_ext[i*MUL_LIMB +: MUL_LIMB]};
      end
    end
  end

  // partial products
  always_ff @(posedge clk) begin
    if (ce) begin
      for (int i = 0; i < NLIMB; i++) begin
        pp_r[i] <= limb[i] * b;
      end
    end
  end

  // first sum level: neighboring limbs
  for (genvar j = 0; j < NPAIR; j++) begin : g_pair
    if (2*j + 1 < NLIMB) begin : g_two
      assign pair_nxt[j] = (ACC_W'(pp_r[2*j]) <<< (2*j*MUL_LIMB))
                         + (ACC_W'(pp_r[2*j+1]) <<< ((2*j+1)*MUL_LIMB));
    end else begin : g_one
      assign pair_nxt[j] = ACC_W'(pp_r[2*j]) <<< (2*j*MUL_LIMB);
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int j = 0; j < NPAIR; j++) begin
        pair_r[j] <= pair_nxt[j];
      end
    end
  end

  // final sum; the exact product fits P_W bits
  always_comb begin
    acc_nxt = '0;
    for (int j = 0; j < NPAIR; j++) begin
      acc_nxt = acc_nxt + pair_r[j];
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      p_r <= acc_nxt[P_W-1:0];
    end
  end

  assign p = p_r;

endmodule

@@ src/rti_classify.sv @@
// Sign fold, barycentric and interval tests. Four stages; the interval
// products run in parallel with the barycentric compares.
module rti_classify
  import rti_pkg::*;
#(
  parameter int COORD_BITS = 32,
  parameter int DET_W      = 102
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         ce,
  input  logic                         in_valid,
  input  logic signed [DET_W-1:0]      det,
  input  logic signed [DET_W-1:0]      un,
  input  logic signed [DET_W-1:0]      vn,
  input  logic signed [DET_W-1:0]      tn,
  input  logic signed [COORD_BITS-1:0] t_low,
  input  logic signed [COORD_BITS-1:0] t_high,
  output logic                         out_valid,
  output rti_result_t                  out_res
);

  localparam int PROD_W = DET_W + COORD_BITS;
  localparam int SUM_W  = DET_W + 1;
  localparam int TSH_W  = DET_W + FRAC_BITS;

  logic [3:0] q_v_r;

  logic                    flip;
  logic signed [DET_W-1:0] det_nxt, un_nxt, vn_nxt, tn_nxt;

  logic                    zero1_r;
  logic signed [DET_W-1:0] det1_r, un1_r, vn1_r, tn1_r;

  logic                    zero2_r, r2_2_r, vneg2_r;
  logic signed [SUM_W-1:0] uv2_r;
  logic signed [DET_W-1:0] det2_r, tn2_r;

  logic                    zero3_r, r2_3_r, r3_3_r;
  logic signed [DET_W-1:0] tn3_r;

  logic                    zero4_r, r2_4_r, r3_4_r;
  logic signed [DET_W-1:0] tn4_r;

  logic signed [PROD_W-1:0] p_lo, p_hi;
  logic signed [TSH_W-1:0]  t_shift;
  logic                     r4;
  logic [2:0]               reason;

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_v_r <= '0;
    end else if (ce) begin
      q_v_r <= {q_v_r[2:0], in_valid};
    end
  end

  // fold the sign of det into all numerators
  assign flip    = det[DET_W-1];
  assign det_nxt = flip ? -det : det;
  assign un_nxt  = flip ? -un  : un;
  assign vn_nxt  = flip ? -vn  : vn;
  assign tn_nxt  = flip ? -tn  : tn;

  always_ff @(posedge clk) begin
    if (ce) begin
      zero1_r <= (det == '0);
      det1_r  <= det_nxt;
      un1_r   <= un_nxt;
      vn1_r   <= vn_nxt;
      tn1_r   <= tn_nxt;
    end
  end

  // first barycentric, and u + v for the second
  always_ff @(posedge clk) begin
    if (ce) begin
      zero2_r <= zero1_r;
      r2_2_r  <= un1_r[DET_W-1] | (det1_r < un1_r);
      uv2_r   <= SUM_W'(un1_r) + SUM_W'(vn1_r);
      vneg2_r <= vn1_r[DET_W-1];
      det2_r  <= det1_r;
      tn2_r   <= tn1_r;
    end
  end

  // second barycentric
  always_ff @(posedge clk) begin
    if (ce) begin
      zero3_r <= zero2_r;
      r2_3_r  <= r2_2_r;
      r3_3_r  <= vneg2_r | (SUM_W'(det2_r) < uv2_r);
      tn3_r   <= tn2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      zero4_r <= zero3_r;
      r2_4_r  <= r2_3_r;
      r3_4_r  <= r3_3_r;
      tn4_r   <= tn3_r;
    end
  end

  // interval bounds scaled by |det|
  rti_mul #(.A_W(DET_W), .B_W(COORD_BITS)) u_mul_lo (
    .clk (clk),
    .ce  (ce),
    .a   (det1_r),
    .b   (t_low),
    .p   (p_lo)
  );

  rti_mul #(.A_W(DET_W), .B_W(COORD_BITS)) u_mul_hi (
    .clk (clk),
    .ce  (ce),
    .a   (det1_r),
    .b   (t_high),
    .p   (p_hi)
  );

  // t numerator in the same scale as t_low * det
  assign t_shift = $signed({tn4_r, {FRAC_BITS{1'b0}}});
  assign r4      = (t_shift < p_lo) || (p_hi < t_shift);

  // first failing test wins
  always_comb begin
    if (zero4_r) begin
      reason = RSN_PARALLEL;
    end else if (r2_4_r) begin
      reason = RSN_BARY_U;
    end else if (r3_4_r) begin
      reason = RSN_BARY_V;
    end else if (r4) begin
      reason = RSN_T_RANGE;
    end else begin
      reason = RSN_HIT;
    end
  end

  assign out_res.reason = reason;
  assign out_res.hit    = (reason == RSN_HIT);
  assign out_valid      = q_v_r[3];

`ifndef SYNTHESIS
  a_det_folded: assert property (@(posedge clk) disable iff (!rst_n)
    (q_v_r[0] && !zero1_r) |-> !det1_r[DET_W-1])
    else $error("determinant negative after sign fold");
`endif

endmodule

@@ src/rti_skid.sv @@
// Output register with a one-word skid stage, so the pipeline keeps
// moving after the sink drops ready, until the skid stage holds a word.
module rti_skid
  import rti_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  rti_result_t in_res,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  output rti_result_t out_res
);

  logic        out_valid_r, skid_valid_r;
  rti_result_t out_res_r, skid_res_r;

  assign in_ready = !skid_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_ready) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end
    end else if (in_valid) begin
      if (!out_valid_r || out_ready) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_ready) begin
        out_res_r <= skid_res_r;
      end
    end else if (in_valid) begin
      if (!out_valid_r || out_ready) begin
        out_res_r <= in_res;
      end else begin
        skid_res_r <= in_res;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid word held while output register empty");

  a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (skid_valid_r && out_ready) |=> (!skid_valid_r && out_valid_r))
    else $error("skid word not moved to output");
`endif

endmodule

@@ src/ray_triangle_intersect.sv @@
// Throughput: one triangle per cycle while in_tready is high; set by the three rows
// of 3-stage limb multipliers (cross products, dot products, interval bounds) all
// pipelined. A stall on the output is taken up by a one-word skid stage ahead of
// the output register; once that is full, in_tready drops and the pipeline holds.
// Reset (rst_n low, synchronous): clears all valid bits and loads the ray registers
// with origin 0, direction (0, 0, 1.0), t_low 0, t_high max.
module ray_triangle_intersect
  import rti_pkg::*;
#(
  parameter int COORD_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z (COORD_BITS each, from bit 0 up)
  input  logic [((NUM_IN_FIELDS*COORD_BITS+7)/8)*8-1:0] in_tdata,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  // hit [0], reject_reason [3:1], zero fill above
  output logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  localparam int EW   = COORD_BITS + 1;
  localparam int SW   = 2*COORD_BITS + 3;
  localparam int DW   = 3*COORD_BITS + 6;
  localparam int P1_W = 2*EW;
  localparam int P2_W = SW + EW;

  logic [CFG_W-1:0]             cfg_r [NUM_REGS];
  logic signed [COORD_BITS-1:0] cfg_c [NUM_REGS];
  logic signed [EW-1:0]         dir_e [3];
  logic signed [COORD_BITS-1:0] org   [3];
  logic signed [COORD_BITS-1:0] vtx   [NUM_IN_FIELDS];

  logic       ce, in_fire;
  logic [8:0] v_r;

  logic signed [EW-1:0] e1_r [5][3];
  logic signed [EW-1:0] e2_r [5][3];
  logic signed [EW-1:0] d_r  [5][3];

  logic signed [P1_W-1:0] p_s1a [3];
  logic signed [P1_W-1:0] p_s1b [3];
  logic signed [P1_W-1:0] p_s2a [3];
  logic signed [P1_W-1:0] p_s2b [3];
  logic signed [SW-1:0]   s1_r  [3];
  logic signed [SW-1:0]   s2_r  [3];

  logic signed [P2_W-1:0] p_det [3];
  logic signed [P2_W-1:0] p_un  [3];
  logic signed [P2_W-1:0] p_vn  [3];
  logic signed [P2_W-1:0] p_tn  [3];
  logic signed [DW-1:0]   det_r, un_r, vn_r, tn_r;

  logic        cls_valid;
  rti_result_t cls_res;
  rti_result_t out_res;

  // ray registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        case (CFG_IDX_W'(i))
          REG_DIR_Z:  cfg_r[i] <= DIR_Z_RESET;
          REG_T_HIGH: cfg_r[i] <= T_HIGH_RESET;
          default:    cfg_r[i] <= '0;
        endcase
      end
    end else if (cfg_we) begin
      cfg_r[cfg_idx] <= cfg_wdata;
    end
  end

  // register values seen at coordinate width, sign taken from bit COORD_BITS-1
  always_comb begin
    for (int i = 0; i < NUM_REGS; i++) begin
      cfg_c[i] = COORD_BITS'({{CFG_W{1'b0}}, cfg_r[i]});
    end
  end

  assign org[0]   = cfg_c[REG_ORIGIN_X];
  assign org[1]   = cfg_c[REG_ORIGIN_Y];
  assign org[2]   = cfg_c[REG_ORIGIN_Z];
  assign dir_e[0] = EW'(cfg_c[REG_DIR_X]);
  assign dir_e[1] = EW'(cfg_c[REG_DIR_Y]);
  assign dir_e[2] = EW'(cfg_c[REG_DIR_Z]);

  // unpack the input word
  always_comb begin
    for (int i = 0; i < NUM_IN_FIELDS; i++) begin
      vtx[i] = in_tdata[i*COORD_BITS +: COORD_BITS];
    end
  end

  assign in_tready = ce;
  assign in_fire   = in_tvalid & ce;

  // valid bits through the front stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (ce) begin
      v_r <= {v_r[7:0], in_fire};
    end
  end

  // edges and origin offset, then delayed to meet the dot products
  always_ff @(posedge clk) begin
    if (ce) begin
      for (int k = 0; k < 3; k++) begin
        e1_r[0][k] <= EW'(vtx[3+k]) - EW'(vtx[k]);
        e2_r[0][k] <= EW'(vtx[6+k]) - EW'(vtx[k]);
        d_r[0][k]  <= EW'(org[k])   - EW'(vtx[k]);
      end
      for (int s = 1; s < 5; s++) begin
        for (int k = 0; k < 3; k++) begin
          e1_r[s][k] <= e1_r[s-1][k];
          e2_r[s][k] <= e2_r[s-1][k];
          d_r[s][k]  <= d_r[s-1][k];
        end
      end
    end
  end

  // cross products s1 = dir x e2 and s2 = d x e1
  for (genvar k = 0; k < 3; k++) begin : g_cross
    localparam int I1 = (k + 1) % 3;
    localparam int I2 = (k + 2) % 3;

    rti_mul #(.A_W(EW), .B_W(EW)) u_s1a (
      .clk (clk), .ce (ce), .a (dir_e[I1]), .b (e2_r[0][I2]), .p (p_s1a[k])
    );
    rti_mul #(.A_W(EW), .B_W(EW)) u_s1b (
      .clk (clk), .ce (ce), .a (dir_e[I2]), .b (e2_r[0][I1]), .p (p_s1b[k])
    );
    rti_mul #(.A_W(EW), .B_W(EW)) u_s2a (
      .clk (clk), .ce (ce), .a (d_r[0][I1]), .b (e1_r[0][I2]), .p (p_s2a[k])
    );
    rti_mul #(.A_W(EW), .B_W(EW)) u_s2b (
      .clk (clk), .ce (ce), .a (d_r[0][I2]), .b (e1_r[0][I1]), .p (p_s2b[k])
    );
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int k = 0; k < 3; k++) begin
        s1_r[k] <= SW'(p_s1a[k]) - SW'(p_s1b[k]);
        s2_r[k] <= SW'(p_s2a[k]) - SW'(p_s2b[k]);
      end
    end
  end

  // dot product terms: det = s1.e1, un = d.s1, vn = dir.s2, tn = e2.s2
  for (genvar k = 0; k < 3; k++) begin : g_dot
    rti_mul #(.A_W(SW), .B_W(EW)) u_det (
      .clk (clk), .ce (ce), .a (s1_r[k]), .b (e1_r[4][k]), .p (p_det[k])
    );
    rti_mul #(.A_W(SW), .B_W(EW)) u_un (
      .clk (clk), .ce (ce), .a (s1_r[k]), .b (d_r[4][k]), .p (p_un[k])
    );
    rti_mul #(.A_W(SW), .B_W(EW)) u_vn (
      .clk (clk), .ce (ce), .a (s2_r[k]), .b (dir_e[k]), .p (p_vn[k])
    );
    rti_mul #(.A_W(SW), .B_W(EW)) u_tn (
      .clk (clk), .ce (ce), .a (s2_r[k]), .b (e2_r[4][k]), .p (p_tn[k])
    );
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      det_r <= DW'(p_det[0]) + DW'(p_det[1]) + DW'(p_det[2]);
      un_r  <= DW'(p_un[0])  + DW'(p_un[1])  + DW'(p_un[2]);
      vn_r  <= DW'(p_vn[0])  + DW'(p_vn[1])  + DW'(p_vn[2]);
      tn_r  <= DW'(p_tn[0])  + DW'(p_tn[1])  + DW'(p_tn[2]);
    end
  end

  rti_classify #(.COORD_BITS(COORD_BITS), .DET_W(DW)) u_classify (
    .clk       (clk),
    .rst_n     (rst_n),
    .ce        (ce),
    .in_valid  (v_r[8]),
    .det       (det_r),
    .un        (un_r),
    .vn        (vn_r),
    .tn        (tn_r),
    .t_low     (cfg_c[REG_T_LOW]),
    .t_high    (cfg_c[REG_T_HIGH]),
    .out_valid (cls_valid),
    .out_res   (cls_res)
  );

  rti_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (cls_valid),
    .in_res    (cls_res),
    .in_ready  (ce),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  assign out_tdata = {{(OUT_TDATA_W-$bits(rti_result_t)){1'b0}}, out_res.reason, out_res.hit};

`ifndef SYNTHESIS
  a_pipe_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !ce |=> $stable(v_r))
    else $error("front valid bits moved during stall");

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> v_r[0])
    else $error("accepted word did not enter the pipeline");
`endif

endmodule

@@ test/rti_hit_check.sv @@
`timescale 1ns / 1ps

// Watches the triangle, result and register ports of the intersection block,
// predicts the hit/reason word for every accepted triangle and compares.
module rti_hit_check
  import rti_pkg::*;
#(
  parameter int COORD_W = 32,
  parameter int TRI_W   = ((NUM_IN_FIELDS*COORD_W+7)/8)*8
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z (COORD_W each, from bit 0 up)
  input  logic [TRI_W-1:0]       in_tdata,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  // hit [0], reject_reason [3:1], zero fill above
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_idx,
  input  logic [CFG_W-1:0]       cfg_wdata,
  output int                     pending,
  output int                     fail_count,
  output int                     checked_count,
  output int                     hit_count,
  output logic [4:0]             reasons_seen
);

  // wide enough for t_high * det (about 134 bits) with room to spare
  typedef logic signed [191:0] big_t;

  logic [CFG_W-1:0] ray_reg [NUM_REGS];
  rti_result_t      verdict_q [$];

  function automatic big_t sext(input logic signed [COORD_W-1:0] c);
    return c;
  endfunction

  function automatic big_t vertex(input logic [TRI_W-1:0] w, input int k);
    return sext(w[k*COORD_W +: COORD_W]);
  endfunction

  // Exact Moller-Trumbore without division: numerators are compared
  // against |det| after flipping signs when det is negative.
  function automatic rti_result_t predict_verdict(input logic [TRI_W-1:0] w);
    rti_result_t r;
    big_t ax, ay, az, e1x, e1y, e1z, e2x, e2y, e2z;
    big_t ox, oy, oz, dx, dy, dz, t_lo, t_hi;
    big_t s1x, s1y, s1z, qx, qy, qz, s2x, s2y, s2z;
    big_t det, un, vn, tn;
    bit   flip;
    ax  = vertex(w, 0);
    ay  = vertex(w, 1);
    az  = vertex(w, 2);
    e1x = vertex(w, 3) - ax;
    e1y = vertex(w, 4) - ay;
    e1z = vertex(w, 5) - az;
    e2x = vertex(w, 6) - ax;
    e2y = vertex(w, 7) - ay;
    e2z = vertex(w, 8) - az;
    ox   = sext(ray_reg[REG_ORIGIN_X]);
    oy   = sext(ray_reg[REG_ORIGIN_Y]);
    oz   = sext(ray_reg[REG_ORIGIN_Z]);
    dx   = sext(ray_reg[REG_DIR_X]);
    dy   = sext(ray_reg[REG_DIR_Y]);
    dz   = sext(ray_reg[REG_DIR_Z]);
    t_lo = sext(ray_reg[REG_T_LOW]);
    t_hi = sext(ray_reg[REG_T_HIGH]);
    r.hit    = 1'b0;
    r.reason = RSN_HIT;

    // s1 = dir x e2, det = s1 . e1
    s1x = dy*e2z - dz*e2y;
    s1y = dz*e2x - dx*e2z;
    s1z = dx*e2y - dy*e2x;
    det = s1x*e1x + s1y*e1y + s1z*e1z;
    if (det == 0) begin
      r.reason = RSN_PARALLEL;
      return r;
    end
    flip = det < 0;
    if (flip) det = -det;

    // first barycentric
    qx = ox - ax;
    qy = oy - ay;
    qz = oz - az;
    un = qx*s1x + qy*s1y + qz*s1z;
    if (flip) un = -un;
    if (un < 0 || un > det) begin
      r.reason = RSN_BARY_U;
      return r;
    end

    // second barycentric and the sum
    s2x = qy*e1z - qz*e1y;
    s2y = qz*e1x - qx*e1z;
    s2z = qx*e1y - qy*e1x;
    vn  = dx*s2x + dy*s2y + dz*s2z;
    if (flip) vn = -vn;
    if (vn < 0 || un + vn > det) begin
      r.reason = RSN_BARY_V;
      return r;
    end

    // ray parameter against the interval, both ends inclusive
    tn = e2x*s2x + e2y*s2y + e2z*s2z;
    if (flip) tn = -tn;
    tn = tn <<< FRAC_BITS;
    if (tn < t_lo*det || tn > t_hi*det) begin
      r.reason = RSN_T_RANGE;
      return r;
    end
    r.hit = 1'b1;
    return r;
  endfunction

  // register mirror, prediction on input words, compare on output words
  always @(posedge clk) begin : watch
    rti_result_t want;
    if (!rst_n) begin
      for (int k = 0; k < NUM_REGS; k++) ray_reg[k] = '0;
      ray_reg[REG_DIR_Z]  = DIR_Z_RESET;
      ray_reg[REG_T_HIGH] = T_HIGH_RESET;
      verdict_q.delete();
      fail_count    = 0;
      checked_count = 0;
      hit_count     = 0;
      reasons_seen  = '0;
    end else begin
      if (in_tvalid && in_tready) verdict_q.push_back(predict_verdict(in_tdata));
      if (out_tvalid && out_tready) begin
        if (verdict_q.size() == 0) begin
          $error("result word %h with no triangle outstanding", out_tdata);
          fail_count++;
        end else begin
          want = verdict_q.pop_front();
          if (out_tdata[0] !== want.hit) begin
            $error("hit: expected %0b, got %0b", want.hit, out_tdata[0]);
            fail_count++;
          end
          if (out_tdata[3:1] !== want.reason) begin
            $error("reject_reason: expected %0d, got %0d", want.reason, out_tdata[3:1]);
            fail_count++;
          end
          if (out_tdata[OUT_TDATA_W-1:4] !== '0) begin
            $error("fill: expected 0, got %h", out_tdata[OUT_TDATA_W-1:4]);
            fail_count++;
          end
          checked_count++;
          if (want.hit) hit_count++;
          reasons_seen[want.reason] = 1'b1;
        end
      end
      if (cfg_we) ray_reg[cfg_idx] = cfg_wdata;
    end
    pending <= verdict_q.size();
  end

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import rti_pkg::*;

  localparam int COORD_W     = 32;
  localparam int TRI_W       = ((NUM_IN_FIELDS*COORD_W+7)/8)*8;
  localparam int PIPE_CYCLES = 16;     // pipeline latency plus skid margin
  localparam int HOLD_CYCLES = 80;
  localparam int CYCLE_LIMIT = 200000;
  localparam int NUM_PHASES  = 7;
  localparam int ONE         = 1 << FRAC_BITS;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z (COORD_W each, from bit 0 up)
  logic [TRI_W-1:0]       in_tdata;
  logic                   out_tvalid;
  logic                   out_tready;
  // hit [0], reject_reason [3:1], zero fill above
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_we;
  logic [CFG_IDX_W-1:0]   cfg_idx;
  logic [CFG_W-1:0]       cfg_wdata;

  int         pending, fail_count, checked_count, hit_count;
  logic [4:0] reasons_seen;
  int         cycle_count = 0;
  int         sent = 0;
  int         ray_settings = 1;
  bit         calm = 1'b0;
  bit         hold_req = 1'b0;

  // local copy of the ray, written to the ray registers and used to aim triangles at it
  logic signed [CFG_W-1:0] ray [NUM_REGS];

  always #5 clk = ~clk;

  always @(posedge clk) cycle_count <= cycle_count + 1;

  ray_triangle_intersect #(.COORD_BITS(COORD_W)) DUT (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata,
    .out_tvalid, .out_tready, .out_tdata,
    .cfg_we, .cfg_idx, .cfg_wdata
  );

  rti_hit_check #(.COORD_W(COORD_W)) hit_check (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata,
    .out_tvalid, .out_tready, .out_tdata,
    .cfg_we, .cfg_idx, .cfg_wdata,
    .pending, .fail_count, .checked_count, .hit_count, .reasons_seen
  );

  function automatic logic signed [31:0] jitter(input int span);
    return int'($urandom_range(0, 2*span)) - span;
  endfunction

  // triangle around the point origin + steps*dir; that point sits at
  // barycentrics (i/3, j/3), or (j/3, i/3) with swap, so edges and corners are hit exactly
  function automatic logic [TRI_W-1:0] aimed_triangle(input int steps, input int i,
                                                      input int j, input bit swap,
                                                      input bit flat);
    logic signed [31:0] p, u, v, a, b, c;
    logic [TRI_W-1:0]   w;
    w = '0;
    for (int k = 0; k < 3; k++) begin
      p = ray[REG_ORIGIN_X + k] + steps * ray[REG_DIR_X + k];
      u = jitter(1 << 18);
      v = flat ? u : jitter(1 << 18);
      a = p - i*u - j*v;
      b = a + 3*u;
      c = a + 3*v;
      w[k*32 +: 32]     = a;
      w[(3+k)*32 +: 32] = swap ? c : b;
      w[(6+k)*32 +: 32] = swap ? b : c;
    end
    return w;
  endfunction

  function automatic logic [TRI_W-1:0] noise_triangle();
    logic [TRI_W-1:0] w;
    logic [31:0]      f;
    w = '0;
    for (int k = 0; k < NUM_IN_FIELDS; k++) begin
      case ($urandom_range(0, 3))
        0: f = $urandom;
        1: begin
          case ($urandom_range(0, 3))
            0: f = 32'h8000_0000;
            1: f = 32'h7fff_ffff;
            2: f = 32'h0000_0000;
            default: f = 32'hffff_ffff;
          endcase
        end
        default: f = jitter(1 << 20);
      endcase
      w[k*32 +: 32] = f;
    end
    return w;
  endfunction

  // mostly well-aimed triangles, the rest arbitrary words
  function automatic logic [TRI_W-1:0] random_triangle();
    if ($urandom_range(0, 99) < 75)
      return aimed_triangle(int'($urandom_range(0, 10)) - 2,
                            int'($urandom_range(0, 5)) - 1,
                            int'($urandom_range(0, 5)) - 1,
                            1'($urandom_range(0, 1)), $urandom_range(0, 19) == 0);
    return noise_triangle();
  endfunction

  task automatic send_triangle(input logic [TRI_W-1:0] w);
    while (!calm && $urandom_range(0, 99) < 28) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= w;
    do @(posedge clk); while (!in_tready);
    sent++;
  endtask

  // quiet the input and wait until every word is back and the pipe is empty
  task automatic settle();
    in_tvalid <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (PIPE_CYCLES) @(posedge clk);
  endtask

  task automatic program_ray();
    settle();
    for (int k = 0; k < NUM_REGS; k++) begin
      cfg_we    <= 1'b1;
      cfg_idx   <= CFG_IDX_W'(k);
      cfg_wdata <= ray[k];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    ray_settings++;
  endtask

  task automatic random_ray(input bit keep_ray);
    if (!keep_ray) begin
      ray[REG_ORIGIN_X] = jitter(1 << 20);
      ray[REG_ORIGIN_Y] = jitter(1 << 20);
      ray[REG_ORIGIN_Z] = jitter(1 << 20);
      ray[REG_DIR_X]    = jitter(1 << 17);
      ray[REG_DIR_Y]    = jitter(1 << 17);
      ray[REG_DIR_Z]    = jitter(1 << 17);
    end
  endtask

  task automatic set_phase(input int ph);
    case (ph)
      0: begin
        random_ray(1'b0);
        ray[REG_T_LOW]  = 0;
        ray[REG_T_HIGH] = 4 * ONE;
      end
      1: begin                         // single-point interval
        random_ray(1'b1);
        ray[REG_T_LOW]  = 2 * ONE;
        ray[REG_T_HIGH] = 2 * ONE;
      end
      2: begin                         // empty interval
        random_ray(1'b0);
        ray[REG_T_LOW]  = 5 * ONE;
        ray[REG_T_HIGH] = ONE;
      end
      3: begin                         // interval behind the origin
        random_ray(1'b0);
        ray[REG_T_LOW]  = -3 * ONE;
        ray[REG_T_HIGH] = 0;
      end
      4: begin                         // zero direction
        random_ray(1'b0);
        ray[REG_DIR_X]  = 0;
        ray[REG_DIR_Y]  = 0;
        ray[REG_DIR_Z]  = 0;
        ray[REG_T_LOW]  = 0;
        ray[REG_T_HIGH] = 8 * ONE;
      end
      5: begin                         // register extremes
        ray[REG_ORIGIN_X] = 32'h7fff_ffff;
        ray[REG_ORIGIN_Y] = 32'h8000_0000;
        ray[REG_ORIGIN_Z] = 32'h7fff_ffff;
        ray[REG_DIR_X]    = 32'h8000_0000;
        ray[REG_DIR_Y]    = 32'h7fff_ffff;
        ray[REG_DIR_Z]    = 32'h8000_0000;
        ray[REG_T_LOW]    = 32'h8000_0000;
        ray[REG_T_HIGH]   = 32'h7fff_ffff;
      end
      default: begin                   // full interval
        random_ray(1'b0);
        ray[REG_T_LOW]  = 32'h8000_0000;
        ray[REG_T_HIGH] = 32'h7fff_ffff;
      end
    endcase
  endtask

  // output side: random back-pressure, plus one long hold when asked
  initial begin
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      out_tready <= calm || ($urandom_range(0, 99) >= 28);
    end
  end

  // run limit
  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk);
    $display("Regression FAIL");
    $finish;
  end

  // stimulus and verdict
  initial begin
    int phase_items [NUM_PHASES] = '{80, 60, 50, 60, 30, 40, 180};
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    cfg_we    <= 1'b0;
    cfg_idx   <= '0;
    cfg_wdata <= '0;
    for (int k = 0; k < NUM_REGS; k++) ray[k] = 0;
    ray[REG_DIR_Z]  = DIR_Z_RESET;
    ray[REG_T_HIGH] = T_HIGH_RESET;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed set against the reset ray (down +z from the origin)
    send_triangle(aimed_triangle(1, 1, 1, 1'b0, 1'b0));   // center hit
    send_triangle(aimed_triangle(2, 0, 0, 1'b0, 1'b0));   // through a corner
    send_triangle(aimed_triangle(1, 3, 0, 1'b0, 1'b0));   // first bary exactly 1
    send_triangle(aimed_triangle(1, 0, 3, 1'b0, 1'b0));   // second bary exactly 1
    send_triangle(aimed_triangle(1, 1, 2, 1'b1, 1'b0));   // sum exactly 1, mirrored
    send_triangle(aimed_triangle(0, 1, 1, 1'b0, 1'b0));   // t on the low end
    send_triangle(aimed_triangle(-1, 1, 1, 1'b0, 1'b0));  // behind the origin
    send_triangle(aimed_triangle(1, 4, 0, 1'b0, 1'b0));   // first bary above 1
    send_triangle(aimed_triangle(1, -1, 1, 1'b0, 1'b0));  // first bary negative
    send_triangle(aimed_triangle(1, 1, -1, 1'b0, 1'b0));  // second bary negative
    send_triangle(aimed_triangle(1, 2, 2, 1'b0, 1'b0));   // sum above 1
    send_triangle(aimed_triangle(1, 1, 1, 1'b0, 1'b1));   // degenerate
    send_triangle(aimed_triangle(3, 1, 1, 1'b1, 1'b0));   // other winding
    send_triangle({NUM_IN_FIELDS{32'h0000_0000}});
    send_triangle({NUM_IN_FIELDS{32'h7fff_ffff}});
    send_triangle({NUM_IN_FIELDS{32'h8000_0000}});
    send_triangle({NUM_IN_FIELDS{32'hffff_ffff}});
    send_triangle({NUM_IN_FIELDS{32'h5555_5555}});
    send_triangle({NUM_IN_FIELDS{32'haaaa_aaaa}});
    send_triangle({{4{32'h7fff_ffff, 32'h8000_0000}}, 32'h7fff_ffff});
    send_triangle({{4{32'h8000_0000, 32'h7fff_ffff}}, 32'h8000_0000});
    send_triangle({32'h7fff_ffff, 32'h0, 32'h8000_0000, 32'h0, 32'h7fff_ffff,
                   32'h8000_0000, 32'h0, 32'h0, 32'h0});

    // random part, one ray setting per phase
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      set_phase(ph);
      program_ray();
      for (int n = 0; n < phase_items[ph]; n++) begin
        if (ph == NUM_PHASES - 1) begin
          calm = (n >= 20 && n < 120);
          if (n == 30) hold_req = 1'b1;   // sender keeps pushing into a stalled sink
        end
        send_triangle(ph == 5 ? noise_triangle() : random_triangle());
      end
      calm = 1'b0;
    end

    settle();
    $display("Covered %0d triangles over %0d ray settings, %0d results checked, %0d hits",
             sent, ray_settings, checked_count, hit_count);
    $display("Reject reasons observed (bit per reason, hit at bit 0): %b", reasons_seen);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
